// ===== hdl/rne_pkg.sv =====
`default_nettype none
package rne_pkg;

    // ASCII codes of the numeral letters
    localparam logic [7:0] CH_M = 8'h4D;
    localparam logic [7:0] CH_D = 8'h44;
    localparam logic [7:0] CH_C = 8'h43;
    localparam logic [7:0] CH_L = 8'h4C;
    localparam logic [7:0] CH_X = 8'h58;
    localparam logic [7:0] CH_V = 8'h56;
    localparam logic [7:0] CH_I = 8'h49;

    // Digit positions, most significant first
    localparam logic [1:0] POS_TH = 2'd0;
    localparam logic [1:0] POS_HU = 2'd1;
    localparam logic [1:0] POS_TE = 2'd2;
    localparam logic [1:0] POS_ON = 2'd3;

    // One decimal-split request: thousands (0..4) and three digits
    typedef struct packed {
        logic [2:0] th;
        logic [3:0] hu;
        logic [3:0] te;
        logic [3:0] on;
    } t_digits;

    // Number of letters a digit produces at a given position
    function automatic logic [2:0] dig_len(input logic [1:0] pos, input logic [3:0] d);
        logic [2:0] len;
        if (pos == POS_TH) begin
            len = d[2:0];
        end else if (d <= 4'd3) begin
            len = d[2:0];
        end else if (d == 4'd4) begin
            len = 3'd2;
        end else if (d <= 4'd8) begin
            len = 3'(d - 4'd4);
        end else begin
            len = 3'd2;
        end
        return len;
    endfunction

    // Letter k of the pattern for digit d at a given position
    function automatic logic [7:0] dig_letter(input logic [1:0] pos, input logic [3:0] d,
                                              input logic [2:0] k);
        logic [7:0] unit;
        logic [7:0] five;
        logic [7:0] ten;
        logic [7:0] ch;
        unique case (pos)
            POS_TH: begin
                unit = CH_M; five = CH_M; ten = CH_M;
            end
            POS_HU: begin
                unit = CH_C; five = CH_D; ten = CH_M;
            end
            POS_TE: begin
                unit = CH_X; five = CH_L; ten = CH_C;
            end
            default: begin
                unit = CH_I; five = CH_V; ten = CH_X;
            end
        endcase
        if (d == 4'd4) begin
            ch = (k == 3'd0) ? unit : five;
        end else if (d == 4'd9) begin
            ch = (k == 3'd0) ? unit : ten;
        end else if (d >= 4'd5) begin
            ch = (k == 3'd0) ? five : unit;
        end else begin
            ch = unit;
        end
        return ch;
    endfunction

    // First position holding a nonzero digit
    function automatic logic [1:0] first_pos(input t_digits dg);
        logic [1:0] p;
        if (dg.th != 3'd0) begin
            p = POS_TH;
        end else if (dg.hu != 4'd0) begin
            p = POS_HU;
        end else if (dg.te != 4'd0) begin
            p = POS_TE;
        end else begin
            p = POS_ON;
        end
        return p;
    endfunction

endpackage
`default_nettype wire

// ===== hdl/rne_front.sv =====
`default_nettype none
module rne_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_take,
    input  wire logic [11:0]     i_value,
    output logic                 o_push,
    output rne_pkg::t_digits     o_dig,
    output logic [1:0]           o_inflight
);
    import rne_pkg::*;

    logic          r1_valid;
    logic [2:0]    r1_th;
    logic [9:0]    r1_rem;
    logic          r2_valid;
    logic [2:0]    r2_th;
    logic [3:0]    r2_hu;
    logic [6:0]    r2_rem;
    logic          r3_valid;
    t_digits       r3_dig;

    logic [2:0]    n1_th;
    logic [9:0]    n1_rem;
    logic [3:0]    n2_hu;
    logic [6:0]    n2_rem;
    logic [3:0]    n3_te;
    logic [3:0]    n3_on;

    // Stage 1: thousands by parallel compares
    always_comb begin
        n1_th  = 3'd0;
        n1_rem = i_value[9:0];
        for (int i = 1; i <= 4; i++) begin
            if (i_value >= 12'(i * 1000)) begin
                n1_th  = 3'(i);
                n1_rem = 10'(i_value - 12'(i * 1000));
            end
        end
    end

    // Stage 2: hundreds of a remainder below 1000
    always_comb begin
        n2_hu  = 4'd0;
        n2_rem = r1_rem[6:0];
        for (int i = 1; i <= 9; i++) begin
            if (r1_rem >= 10'(i * 100)) begin
                n2_hu  = 4'(i);
                n2_rem = 7'(r1_rem - 10'(i * 100));
            end
        end
    end

    // Stage 3: tens and ones of a remainder below 100
    always_comb begin
        n3_te = 4'd0;
        n3_on = r2_rem[3:0];
        for (int i = 1; i <= 9; i++) begin
            if (r2_rem >= 7'(i * 10)) begin
                n3_te = 4'(i);
                n3_on = 4'(r2_rem - 7'(i * 10));
            end
        end
    end

    // Pipeline valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else begin
            r1_valid <= i_take;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    // Pipeline payload
    always_ff @(posedge i_clk) begin
        r1_th     <= n1_th;
        r1_rem    <= n1_rem;
        r2_th     <= r1_th;
        r2_hu     <= n2_hu;
        r2_rem    <= n2_rem;
        r3_dig.th <= r2_th;
        r3_dig.hu <= r2_hu;
        r3_dig.te <= n3_te;
        r3_dig.on <= n3_on;
    end

    // Zero yields no letters and is dropped here
    assign o_push     = r3_valid && (r3_dig != '0);
    assign o_dig      = r3_dig;
    assign o_inflight = 2'(r1_valid) + 2'(r2_valid) + 2'(r3_valid);

endmodule
`default_nettype wire

// ===== hdl/rne_queue.sv =====
`default_nettype none
module rne_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    input  wire rne_pkg::t_digits              i_dig,
    input  wire logic                          i_pop,
    output logic                               o_valid,
    output rne_pkg::t_digits                   o_dig,
    output logic [$clog2(DEPTH+1)-1:0]         o_count
);
    import rne_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_digits        r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr;
    logic [AW-1:0]  r_rd_ptr;
    logic [CW-1:0]  r_count;

    // Storage write
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_dig;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

    assign o_valid = (r_count != '0);
    assign o_dig   = r_mem[r_rd_ptr];
    assign o_count = r_count;

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (r_count < CW'(DEPTH)) || i_pop)
        else $error("queue push while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> (r_count != '0))
        else $error("queue pop while empty");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
`endif

endmodule
`default_nettype wire

// ===== hdl/rne_back.sv =====
`default_nettype none
module rne_back (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    input  wire rne_pkg::t_digits  i_dig,
    output logic                   o_pop,
    output logic                   o_strobe,
    output logic [7:0]             o_letter,
    output logic                   o_final_letter
);
    import rne_pkg::*;

    logic          r_active;
    t_digits       r_dig;
    logic [1:0]    r_pos;
    logic [2:0]    r_k;
    logic          r_strobe;
    logic [7:0]    r_letter;
    logic          r_final;

    logic [3:0]    w_d [4];
    logic [3:0]    w_cur;
    logic [2:0]    w_len;
    logic          w_last_in;
    logic          w_rest_nz;
    logic [1:0]    w_nxt_pos;
    logic          w_done;
    logic          w_load;

    // Current digit, its pattern length, and the next nonzero digit
    always_comb begin
        w_d[0] = {1'b0, r_dig.th};
        w_d[1] = r_dig.hu;
        w_d[2] = r_dig.te;
        w_d[3] = r_dig.on;
        w_cur     = w_d[r_pos];
        w_len     = dig_len(r_pos, w_cur);
        w_last_in = (r_k == w_len - 3'd1);
        w_rest_nz = 1'b0;
        w_nxt_pos = POS_ON;
        for (int j = 3; j >= 1; j--) begin
            if ((2'(j) > r_pos) && (w_d[j] != 4'd0)) begin
                w_rest_nz = 1'b1;
                w_nxt_pos = 2'(j);
            end
        end
        w_done = r_active && w_last_in && !w_rest_nz;
        w_load = i_valid && (!r_active || w_done);
    end

    // Letter sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
        end else if (w_load) begin
            r_active <= 1'b1;
        end else if (w_done) begin
            r_active <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_dig <= i_dig;
            r_pos <= first_pos(i_dig);
            r_k   <= 3'd0;
        end else if (r_active) begin
            if (!w_last_in) begin
                r_k <= r_k + 3'd1;
            end else begin
                r_pos <= w_nxt_pos;
                r_k   <= 3'd0;
            end
        end
    end

    // Registered result
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= r_active;
        end
    end

    always_ff @(posedge i_clk) begin
        r_letter <= dig_letter(r_pos, w_cur, r_k);
        r_final  <= w_done;
    end

    assign o_pop          = w_load;
    assign o_strobe       = r_strobe;
    assign o_letter       = r_letter;
    assign o_final_letter = r_final;

`ifndef SYNTHESIS
    a_letter_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_strobe |-> (r_letter == CH_M) || (r_letter == CH_D) || (r_letter == CH_C) ||
                     (r_letter == CH_L) || (r_letter == CH_X) || (r_letter == CH_V) ||
                     (r_letter == CH_I))
        else $error("illegal numeral letter");
    a_active_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_active |-> (w_len != 3'd0) && (r_k < w_len))
        else $error("sequencer on an empty digit");
    a_final_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && !r_final) |-> r_active)
        else $error("numeral ended without final letter");
`endif

endmodule
`default_nettype wire

// ===== hdl/roman_numeral_encoder_top.sv =====
`default_nettype none
// With an idle queue and sequencer, an accepted request passes the splitter stages,
// a queue slot, the sequencer and its output register before its first letter strobes.
// Throughput: one letter per cycle while the sequencer holds a numeral; a numeral has
// 1 to 15 letters, and a zero request never reaches the back end and produces nothing.
// busy rises when the three-stage digit splitter plus the queue hold QUEUE_DEPTH requests.
// Reset: synchronous, active low; clears pipeline, queue and sequencer.
module roman_numeral_encoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire logic [11:0]   i_value,
    output logic               o_strobe,
    output logic [7:0]         o_letter,
    output logic               o_final_letter
);
    import rne_pkg::*;

    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    logic            w_take;
    logic            w_push;
    t_digits         w_push_dig;
    logic [1:0]      w_inflight;
    logic            w_q_valid;
    t_digits         w_q_dig;
    logic            w_pop;
    logic [CW-1:0]   w_count;

    // Credit check: every request in the splitter has a queue slot reserved
    assign busy   = (int'(w_count) + int'(w_inflight)) >= QUEUE_DEPTH;
    assign w_take = start && !busy;

    rne_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_take     (w_take),
        .i_value    (i_value),
        .o_push     (w_push),
        .o_dig      (w_push_dig),
        .o_inflight (w_inflight)
    );

    rne_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_dig   (w_push_dig),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_dig   (w_q_dig),
        .o_count (w_count)
    );

    rne_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (w_q_valid),
        .i_dig          (w_q_dig),
        .o_pop          (w_pop),
        .o_strobe       (o_strobe),
        .o_letter       (o_letter),
        .o_final_letter (o_final_letter)
    );

endmodule
`default_nettype wire

// ===== tb/tb_roman_numeral_encoder_top.sv =====
`timescale 1ns / 1ps

// One expected numeral character
typedef struct {
    logic [7:0] letter;
    logic       last;
} t_expected_letter;

// Predicts the letter stream of each accepted request and checks the output against it
class letter_scoreboard;
    t_expected_letter expected_letters[$];
    logic [7:0]       numeral[$];
    int unsigned      mismatch_count;

    function new();
        mismatch_count = 0;
    endfunction

    task report_mismatch(input string msg);
        $display("MISMATCH @%0t: %s", $realtime, msg);
        mismatch_count++;
    endtask

    function int pending_count();
        return expected_letters.size();
    endfunction

    // Letters of one decimal digit with its unit, five and ten letters
    function void add_digit(input int unsigned d, input logic [7:0] unit,
                            input logic [7:0] five, input logic [7:0] ten);
        if (d >= 1 && d <= 3) begin
            repeat (d) numeral.push_back(unit);
        end else if (d == 4) begin
            numeral.push_back(unit);
            numeral.push_back(five);
        end else if (d >= 5 && d <= 8) begin
            numeral.push_back(five);
            repeat (d - 5) numeral.push_back(unit);
        end else if (d == 9) begin
            numeral.push_back(unit);
            numeral.push_back(ten);
        end
    endfunction

    // Accepted request: queue up its numeral, last letter flagged
    function void note_request(input logic [11:0] value);
        int unsigned v;
        int unsigned thousands;
        t_expected_letter e;
        v = value;
        thousands = v / 1000;
        numeral.delete();
        repeat (thousands) numeral.push_back(rne_pkg::CH_M);
        add_digit((v % 1000) / 100, rne_pkg::CH_C, rne_pkg::CH_D, rne_pkg::CH_M);
        add_digit((v % 100) / 10, rne_pkg::CH_X, rne_pkg::CH_L, rne_pkg::CH_C);
        add_digit(v % 10, rne_pkg::CH_I, rne_pkg::CH_V, rne_pkg::CH_X);
        for (int i = 0; i < numeral.size(); i++) begin
            e.letter = numeral[i];
            e.last   = (i == numeral.size() - 1);
            expected_letters.push_back(e);
        end
    endfunction

    // One output letter against the oldest expectation
    task check_letter(input logic [7:0] letter, input logic last);
        t_expected_letter e;
        if (expected_letters.size() == 0) begin
            report_mismatch($sformatf("unexpected letter 0x%02h last=%0b", letter, last));
        end else begin
            e = expected_letters.pop_front();
            if (letter !== e.letter)
                report_mismatch($sformatf("letter 0x%02h, expected 0x%02h",
                                          letter, e.letter));
            if (last !== e.last)
                report_mismatch($sformatf("final_letter %0b, expected %0b", last, e.last));
        end
    endtask
endclass

module tb_roman_numeral_encoder_top;
    import rne_pkg::*;

    localparam int unsigned CYCLE_LIMIT  = 60000;
    localparam int          RANDOM_ITEMS = 100;
    localparam int          SETTLE       = 24;

    logic        i_clk;
    logic        i_rst_n;
    logic        start;
    logic        busy;
    logic [11:0] i_value;
    logic        o_strobe;
    logic [7:0]  o_letter;
    logic        o_final_letter;

    int unsigned      cycle_count;
    letter_scoreboard sb;

    roman_numeral_encoder_top i_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_value        (i_value),
        .o_strobe       (o_strobe),
        .o_letter       (o_letter),
        .o_final_letter (o_final_letter)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Output monitor
    always @(posedge i_clk) begin
        if (i_rst_n && o_strobe)
            sb.check_letter(o_letter, o_final_letter);
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Hold one request until accepted; returns at the next falling edge
    task send_request(input logic [11:0] v);
        start   = 1'b1;
        i_value = v;
        do @(posedge i_clk); while (busy);
        sb.note_request(v);
        @(negedge i_clk);
    endtask

    task idle_cycles(input int n);
        if (n > 0) begin
            start   = 1'b0;
            i_value = 12'($urandom);
            repeat (n) @(negedge i_clk);
        end
    endtask

    // Stop sending until every letter has come out, then let the pipeline settle
    task drain_letters();
        start = 1'b0;
        while (sb.pending_count() != 0) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    function logic [11:0] pick_value();
        int unsigned sel;
        sel = $urandom_range(0, 11);
        case (sel)
            0:       return 12'd0;
            1:       return 12'($urandom_range(4000, 4095));
            2:       return 12'($urandom_range(1, 20));
            3:       return 12'($urandom_range(3000, 3999));
            default: return 12'($urandom_range(0, 3999));
        endcase
    endfunction

    // Extremes, the digit patterns for 1, 3, 4, 5, 8 and 9, zero and the above-range values
    logic [11:0] directed_values[] = '{
        12'd0, 12'd1, 12'd3, 12'd4, 12'd5, 12'd8, 12'd9, 12'd0, 12'd40, 12'd90,
        12'd400, 12'd900, 12'd1000, 12'd1994, 12'd2048, 12'd444, 12'd999,
        12'd3888, 12'd3999, 12'd4000, 12'd4088, 12'd4095, 12'd49, 12'd14
    };

    initial begin
        int sent;
        int burst;
        int gap_mode;
        bit paused;
        sb          = new();
        cycle_count = 0;
        start       = 1'b0;
        i_value     = 12'd0;
        i_rst_n     = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n = 1'b1;
        repeat (2) @(negedge i_clk);

        // Directed: back to back for the first half, then with gaps
        foreach (directed_values[i]) begin
            send_request(directed_values[i]);
            if (i >= directed_values.size() / 2)
                idle_cycles($urandom_range(0, 5));
        end
        drain_letters();

        // Random bursts with random gaps, one full pause midway
        sent   = 0;
        paused = 1'b0;
        while (sent < RANDOM_ITEMS) begin
            burst = $urandom_range(1, 8);
            repeat (burst) begin
                send_request(pick_value());
                sent++;
            end
            gap_mode = $urandom_range(0, 9);
            if (gap_mode < 4)
                idle_cycles(0);
            else if (gap_mode < 7)
                idle_cycles($urandom_range(1, 3));
            else
                idle_cycles($urandom_range(4, 20));
            if (!paused && sent >= RANDOM_ITEMS / 2) begin
                drain_letters();
                paused = 1'b1;
            end
        end
        drain_letters();

        if (sb.pending_count() != 0)
            sb.report_mismatch($sformatf("%0d letters never came out", sb.pending_count()));
        if (sb.mismatch_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule

// ===== roman_numeral_encoder_top.f =====
hdl/rne_pkg.sv
hdl/rne_front.sv
hdl/rne_queue.sv
hdl/rne_back.sv
hdl/roman_numeral_encoder_top.sv
tb/tb_roman_numeral_encoder_top.sv
